[design/u8u16_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared types, byte classes and code unit constants for the transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam logic [15:0] REPLACE_UNIT   = 16'h003F;
  localparam logic [15:0] HIGH_SURROGATE = 16'hD800;
  localparam logic [15:0] LOW_SURROGATE  = 16'hDC00;
  localparam logic [20:0] PLANE_ONE      = 21'h10000;

  typedef enum logic [2:0] {
    CLS_CONT  = 3'd0,
    CLS_ASCII = 3'd1,
    CLS_LEAD2 = 3'd2,
    CLS_LEAD3 = 3'd3,
    CLS_LEAD4 = 3'd4,
    CLS_BAD   = 3'd5
  } utf8_class_t;

  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_UNIT = 2'd1,
    TAIL_REPL = 2'd2,
    TAIL_PAIR = 2'd3
  } tail_kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_replacement;
    logic        run_last;
    logic        string_end;
  } result_t;

  // Work for the back end: a run of replacements, then an optional tail.
  typedef struct packed {
    logic [1:0]  rep_count;
    tail_kind_t  tail;
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        eos;
  } desc_t;

  function automatic utf8_class_t utf8_class(input logic [7:0] b);
    utf8_class_t cls;
    case (b[7:3]) inside
      [5'd0:5'd15]:   cls = CLS_ASCII;
      [5'd16:5'd23]:  cls = CLS_CONT;
      [5'd24:5'd27]:  cls = CLS_LEAD2;
      [5'd28:5'd29]:  cls = CLS_LEAD3;
      5'd30:          cls = CLS_LEAD4;
      default:        cls = CLS_BAD;
    endcase
    return cls;
  endfunction

endpackage

[design/u8u16_front.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder front end
// Classifies each byte, tracks the pending sequence and builds the work
// descriptor that the back end expands into code units.
// ----------------------------------------------------------------------------
module u8u16_front (
  input  logic             clk,
  input  logic             rst,
  input  u8u16_pkg::item_t item,
  input  logic             accept,
  output u8u16_pkg::desc_t desc,
  output logic             desc_valid
);
  import u8u16_pkg::*;

  logic [1:0]  held;
  logic [2:0]  seq_len;
  logic [20:0] point;
  logic [1:0]  held_next;
  logic [2:0]  seq_len_next;
  logic [20:0] point_next;

  utf8_class_t cls;
  logic [2:0]  held_inc;
  logic [20:0] new_point;
  logic [20:0] offset;
  logic        fresh;
  logic        eos;

  always_comb begin
    cls          = utf8_class(item.in_byte);
    eos          = item.end_of_string;
    held_inc     = {1'b0, held} + 3'd1;
    new_point    = {point[14:0], item.in_byte[5:0]};
    offset       = new_point - PLANE_ONE;
    held_next    = held;
    seq_len_next = seq_len;
    point_next   = point;
    desc         = '0;
    desc.tail    = TAIL_NONE;
    desc.eos     = eos;
    fresh        = 1'b1;

    if (held != 2'd0) begin
      if (cls == CLS_CONT) begin
        fresh = 1'b0;
        if (held_inc >= seq_len) begin
          if (new_point < PLANE_ONE) begin
            desc.tail  = TAIL_UNIT;
            desc.unit0 = new_point[15:0];
          end else begin
            desc.tail  = TAIL_PAIR;
            desc.unit0 = HIGH_SURROGATE | {5'd0, offset[20:10]};
            desc.unit1 = LOW_SURROGATE | {6'd0, offset[9:0]};
          end
          held_next    = '0;
          seq_len_next = '0;
          point_next   = '0;
        end else if (eos) begin
          desc.rep_count = held_inc[1:0];
          held_next      = '0;
          seq_len_next   = '0;
          point_next     = '0;
        end else begin
          held_next  = held_inc[1:0];
          point_next = new_point;
        end
      end else begin
        desc.rep_count = held;
        held_next      = '0;
        seq_len_next   = '0;
        point_next     = '0;
      end
    end

    if (fresh) begin
      case (cls)
        CLS_ASCII: begin
          desc.tail  = TAIL_UNIT;
          desc.unit0 = {8'd0, item.in_byte};
        end
        CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
          if (eos) begin
            desc.tail = TAIL_REPL;
          end else begin
            held_next    = 2'd1;
            seq_len_next = cls;
            if (cls == CLS_LEAD2) begin
              point_next = {16'd0, item.in_byte[4:0]};
            end else if (cls == CLS_LEAD3) begin
              point_next = {17'd0, item.in_byte[3:0]};
            end else begin
              point_next = {18'd0, item.in_byte[2:0]};
            end
          end
        end
        default: begin
          desc.tail = TAIL_REPL;
        end
      endcase
    end

    if (eos) begin
      held_next    = '0;
      seq_len_next = '0;
      point_next   = '0;
    end

    desc_valid = (desc.rep_count != 2'd0) || (desc.tail != TAIL_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= '0;
      seq_len <= '0;
      point   <= '0;
    end else if (accept) begin
      held    <= held_next;
      seq_len <= seq_len_next;
      point   <= point_next;
    end
  end

endmodule

[design/u8u16_queue.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder descriptor queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module u8u16_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  u8u16_pkg::desc_t wr_data,
  input  logic             rd_en,
  output u8u16_pkg::desc_t rd_data,
  output logic             full,
  output logic             not_empty
);
  import u8u16_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t            entries [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        if (wr_ptr == IDX_W'(DEPTH - 1)) begin
          wr_ptr <= '0;
        end else begin
          wr_ptr <= wr_ptr + 1'b1;
        end
      end
      if (rd_en) begin
        if (rd_ptr == IDX_W'(DEPTH - 1)) begin
          rd_ptr <= '0;
        end else begin
          rd_ptr <= rd_ptr + 1'b1;
        end
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/u8u16_back.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder back end
// Expands each descriptor into code units in the output register, one per
// cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module u8u16_back (
  input  logic               clk,
  input  logic               rst,
  input  u8u16_pkg::desc_t   desc,
  input  logic               desc_valid,
  output logic               desc_take,
  input  logic               pop,
  output logic               empty,
  output u8u16_pkg::result_t result
);
  import u8u16_pkg::*;

  logic [1:0] idx;
  logic       out_valid;
  logic [2:0] tail_len;
  logic [2:0] total;
  logic [1:0] pos;
  logic       last;
  logic       advance;
  result_t    unit_next;

  always_comb begin
    case (desc.tail)
      TAIL_UNIT: tail_len = 3'd1;
      TAIL_REPL: tail_len = 3'd1;
      TAIL_PAIR: tail_len = 3'd2;
      default:   tail_len = 3'd0;
    endcase
    total = {1'b0, desc.rep_count} + tail_len;
    pos   = idx - desc.rep_count;
    last  = (({1'b0, idx} + 3'd1) == total);

    unit_next.run_last   = last;
    unit_next.string_end = last && desc.eos;
    if (idx < desc.rep_count || desc.tail == TAIL_REPL) begin
      unit_next.code_unit      = REPLACE_UNIT;
      unit_next.is_replacement = 1'b1;
    end else begin
      unit_next.is_replacement = 1'b0;
      if (desc.tail == TAIL_PAIR && pos != 2'd0) begin
        unit_next.code_unit = desc.unit1;
      end else begin
        unit_next.code_unit = desc.unit0;
      end
    end

    advance   = desc_valid && (!out_valid || pop);
    desc_take = advance && last;
    empty     = !out_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= unit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (last) begin
          idx <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[design/utf8_to_utf16_transcoder_unit.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Streams UTF-8 bytes in and UTF-16 code units out, replacing bad bytes.
// ----------------------------------------------------------------------------
// One byte is accepted every cycle while the descriptor queue has room. The
// front end classifies the byte and updates the pending sequence in the same
// cycle, and the back end emits one code unit per cycle while the output
// register is empty or being popped, so a byte that produces n units (up to
// four) keeps the back end busy while the queue of QUEUE_DEPTH entries
// absorbs the difference. The first unit of a byte is written to the queue
// and then to the output register before it is on the result port. Bytes that
// only extend a sequence produce no unit.
module utf8_to_utf16_transcoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  u8u16_pkg::item_t   item,
  output logic               empty,
  input  logic               pop,
  output u8u16_pkg::result_t result
);
  import u8u16_pkg::*;

  logic  accept;
  desc_t front_desc;
  logic  front_valid;
  desc_t head_desc;
  logic  head_valid;
  logic  head_take;

  assign accept = push && !full;

  u8u16_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .accept     (accept),
    .desc       (front_desc),
    .desc_valid (front_valid)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (accept && front_valid),
    .wr_data   (front_desc),
    .rd_en     (head_take),
    .rd_data   (head_desc),
    .full      (full),
    .not_empty (head_valid)
  );

  u8u16_back u_back (
    .clk        (clk),
    .rst        (rst),
    .desc       (head_desc),
    .desc_valid (head_valid),
    .desc_take  (head_take),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule
